// File: src/rrafr_pkg.sv
// Package for the RR artifact filter / RMSSD block: sizes, register codes,
// reset values and the control structs passed between its modules.
// No dependencies.
package rrafr_pkg;

  localparam int RR_BITS_DEF       = 12;
  localparam int MAX_INTERVALS_DEF = 1024;

  localparam int THR_W     = 16;
  localparam int MINK_W    = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ARTIFACT_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_KEPT           = 1'd1;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd13107;
  localparam logic [MINK_W-1:0] MINK_RESET = 11'd30;

  localparam int RMSSD_W       = 16;
  localparam int HR_W          = 24;
  localparam int KEPT_COUNT_W  = 11;
  localparam int DIFF_COUNT_W  = 10;
  localparam int RMS_FRAC_BITS = 8;
  localparam int MIN_DIFFS     = 2;

  localparam logic [RMSSD_W-1:0] RMSSD_MAX = 16'hFFFF;
  localparam logic [HR_W-1:0]    HR_MAX    = 24'hFFFFFF;
  // 60000 bpm*ms in 1/256 bpm
  localparam logic [HR_W-1:0]    HR_SCALE  = 24'd15360000;

  // default width of the shared divide/root unit for the default sizes
  localparam int DIVSQRT_W_DEF = 44;

  typedef struct packed {
    logic start;
    logic last;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic done;
    logic invalid;
  } win_stat_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } unit_ctrl_t;

endpackage

// File: src/rrafr_if.sv
// Stream interfaces for the RR artifact filter: interval requests in,
// window summary requests out. Depends on rrafr_pkg.
interface rrafr_in_if import rrafr_pkg::*; #(
  parameter int RR_BITS = RR_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [RR_BITS-1:0] rr_ms;
  logic               last_interval;

  modport source (output valid, output rr_ms, output last_interval, input ready);
  modport sink   (input valid, input rr_ms, input last_interval, output ready);
endinterface

interface rrafr_out_if import rrafr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [RMSSD_W-1:0]      rmssd_q4;
  logic                    rmssd_valid;
  logic [HR_W-1:0]         mean_hr_q8;
  logic                    mean_hr_valid;
  logic [KEPT_COUNT_W-1:0] kept_count;
  logic [DIFF_COUNT_W-1:0] diff_count;
  logic                    usable;
  logic                    window_invalid;

  modport source (
    output valid, output rmssd_q4, output rmssd_valid, output mean_hr_q8,
    output mean_hr_valid, output kept_count, output diff_count, output usable,
    output window_invalid, input ready
  );
  modport sink (
    input valid, input rmssd_q4, input rmssd_valid, input mean_hr_q8,
    input mean_hr_valid, input kept_count, input diff_count, input usable,
    input window_invalid, output ready
  );
endinterface

// File: src/rr_artifact_filter_rmssd.sv
// RR artifact filter and RMSSD / mean heart rate over one window.
// Intervals are filtered one at a time by the filter sequencer around its one
// multiplier; a new interval is taken only once the last one is through. A
// last interval's summary then runs through the shared divide/root unit
// (W = 44 bits by default) and is registered, held back by any output stall.
// Synchronous active-high reset clears the window and loads register defaults.
module rr_artifact_filter_rmssd import rrafr_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int RR_BITS       = RR_BITS_DEF,
  localparam int CNT_W   = $clog2(MAX_INTERVALS + 1),
  localparam int RSUM_W  = RR_BITS + CNT_W,
  localparam int SQ_W    = 2 * RR_BITS + CNT_W,
  localparam int MS_W    = SQ_W + RMS_FRAC_BITS,
  localparam int NUM_W   = HR_W + CNT_W,
  localparam int RAW_W   = (MS_W > NUM_W) ? MS_W : NUM_W,
  localparam int UNIT_W  = RAW_W + (RAW_W % 2),
  localparam int ROOT_W  = UNIT_W / 2,
  localparam int RX_W    = (ROOT_W > RMSSD_W) ? ROOT_W : RMSSD_W,
  localparam int CMP_W   = (CNT_W > MINK_W) ? CNT_W : MINK_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rrafr_in_if.sink             beat,
  rrafr_out_if.source          summary
);

  localparam logic [3:0] T_IDLE      = 4'd0;
  localparam logic [3:0] T_ITEM      = 4'd1;
  localparam logic [3:0] T_DIV_GO    = 4'd2;
  localparam logic [3:0] T_DIV_WAIT  = 4'd3;
  localparam logic [3:0] T_SQRT_GO   = 4'd4;
  localparam logic [3:0] T_SQRT_WAIT = 4'd5;
  localparam logic [3:0] T_HR_GO     = 4'd6;
  localparam logic [3:0] T_HR_WAIT   = 4'd7;
  localparam logic [3:0] T_FIN       = 4'd8;

  logic [3:0]        state;
  logic              item_last;
  logic [THR_W-1:0]  threshold;
  logic [MINK_W-1:0] min_kept;
  logic [ROOT_W-1:0] root;

  win_ctrl_t         win_ctrl;
  win_stat_t         win_stat;
  logic [CNT_W-1:0]  kept_total;
  logic [CNT_W-1:0]  pair_total;
  logic [RSUM_W-1:0] kept_rr_sum;
  logic [SQ_W-1:0]   squared_diff_sum;

  unit_ctrl_t        unit_ctrl;
  logic [UNIT_W-1:0] operand;
  logic [UNIT_W-1:0] divisor;
  logic              unit_done;
  logic [UNIT_W-1:0] unit_result;
  logic [NUM_W-1:0]  hr_num;

  logic               accept;
  logic               load;
  logic               out_valid;
  logic               inv;
  logic               rv;
  logic               hv;
  logic [RMSSD_W-1:0] rms_sat;
  logic [HR_W-1:0]    hr_sat;
  logic [RMSSD_W-1:0] rms_o;
  logic [HR_W-1:0]    hr_o;
  logic               use_o;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
      min_kept  <= MINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARTIFACT_THRESHOLD: threshold <= cfg_data[THR_W-1:0];
        REG_MIN_KEPT:           min_kept  <= cfg_data[MINK_W-1:0];
        default: ;
      endcase
    end
  end

  assign beat.ready     = (state == T_IDLE);
  assign accept         = beat.valid && beat.ready;
  assign load           = (state == T_FIN) && (!out_valid || summary.ready);

  assign win_ctrl.start = accept;
  assign win_ctrl.last  = beat.last_interval;
  assign win_ctrl.clear = load;

  rrafr_window #(
    .RR_BITS       (RR_BITS),
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_window (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (win_ctrl),
    .rr               (beat.rr_ms),
    .threshold        (threshold),
    .stat             (win_stat),
    .kept_total       (kept_total),
    .pair_total       (pair_total),
    .kept_rr_sum      (kept_rr_sum),
    .squared_diff_sum (squared_diff_sum)
  );

  always_comb begin
    hr_num              = NUM_W'(HR_SCALE) * NUM_W'(kept_total);
    unit_ctrl.start     = (state == T_DIV_GO) || (state == T_SQRT_GO) || (state == T_HR_GO);
    unit_ctrl.sqrt_mode = (state == T_SQRT_GO);
    operand             = UNIT_W'({squared_diff_sum, {RMS_FRAC_BITS{1'b0}}});
    divisor             = UNIT_W'(pair_total);
    case (state)
      T_SQRT_GO: operand = unit_result;
      T_HR_GO: begin
        operand = UNIT_W'(hr_num);
        divisor = UNIT_W'(kept_rr_sum);
      end
      default: ;
    endcase
  end

  rrafr_divsqrt #(
    .WIDTH (UNIT_W)
  ) u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (unit_ctrl),
    .operand (operand),
    .divisor (divisor),
    .done    (unit_done),
    .result  (unit_result)
  );

  // result fields
  always_comb begin
    inv     = win_stat.invalid;
    rv      = !inv && (pair_total != '0);
    hv      = !inv && (kept_total != '0);
    rms_sat = (RX_W'(root) > RX_W'(RMSSD_MAX)) ? RMSSD_MAX : RMSSD_W'(root);
    hr_sat  = (unit_result > UNIT_W'(HR_MAX)) ? HR_MAX : HR_W'(unit_result);
    rms_o   = rv ? rms_sat : '0;
    hr_o    = hv ? hr_sat : '0;
    use_o   = !inv && (CMP_W'(kept_total) >= CMP_W'(min_kept)) &&
              (pair_total >= CNT_W'(MIN_DIFFS)) && (rms_o != '0) && (hr_o != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            item_last <= beat.last_interval;
            state     <= T_ITEM;
          end
        end
        T_ITEM: begin
          if (win_stat.done) begin
            state <= item_last ? T_DIV_GO : T_IDLE;
          end
        end
        T_DIV_GO:    state <= T_DIV_WAIT;
        T_DIV_WAIT:  if (unit_done) state <= T_SQRT_GO;
        T_SQRT_GO:   state <= T_SQRT_WAIT;
        T_SQRT_WAIT: begin
          if (unit_done) begin
            root  <= unit_result[ROOT_W-1:0];
            state <= T_HR_GO;
          end
        end
        T_HR_GO:     state <= T_HR_WAIT;
        T_HR_WAIT:   if (unit_done) state <= T_FIN;
        T_FIN:       if (load) state <= T_IDLE;
        default:     state <= T_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (summary.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      summary.rmssd_q4       <= rms_o;
      summary.rmssd_valid    <= rv;
      summary.mean_hr_q8     <= hr_o;
      summary.mean_hr_valid  <= hv;
      summary.kept_count     <= inv ? '0 : KEPT_COUNT_W'(kept_total);
      summary.diff_count     <= inv ? '0 : DIFF_COUNT_W'(pair_total);
      summary.usable         <= use_o;
      summary.window_invalid <= inv;
    end
  end

  assign summary.valid = out_valid;

endmodule

// File: src/rrafr_divsqrt.sv
// Shared shift/compare/subtract unit: restoring divide (one quotient bit a
// cycle) or integer square root (one root bit a cycle). Depends on rrafr_pkg.
module rrafr_divsqrt import rrafr_pkg::*; #(
  parameter int WIDTH = DIVSQRT_W_DEF,
  localparam int CNT_W = $clog2(WIDTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  unit_ctrl_t       ctrl,
  input  logic [WIDTH-1:0] operand,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  logic             busy;
  logic             sqrt_mode;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] opnd;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH+1:0] rem;
  logic [WIDTH-1:0] res;
  logic [WIDTH+1:0] rem_sh;
  logic [WIDTH+1:0] trial;
  logic             take;

  always_comb begin
    if (sqrt_mode) begin
      rem_sh = {rem[WIDTH-1:0], opnd[WIDTH-1 -: 2]};
      trial  = {res, 2'b01};
    end else begin
      rem_sh = {rem[WIDTH:0], opnd[WIDTH-1]};
      trial  = {2'b00, dvs};
    end
    take = rem_sh >= trial;
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy      <= 1'b1;
        sqrt_mode <= ctrl.sqrt_mode;
        opnd      <= operand;
        dvs       <= divisor;
        rem       <= '0;
        res       <= '0;
        cnt       <= ctrl.sqrt_mode ? CNT_W'(WIDTH / 2) : CNT_W'(WIDTH);
      end else if (busy) begin
        rem  <= take ? rem_sh - trial : rem_sh;
        res  <= {res[WIDTH-2:0], take};
        opnd <= sqrt_mode ? {opnd[WIDTH-3:0], 2'b00} : {opnd[WIDTH-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/rrafr_window.sv
// Per-interval artifact filter and window accumulators, sequenced through the
// right, left, retire and end states around one shared multiplier. Depends on rrafr_pkg.
module rrafr_window import rrafr_pkg::*; #(
  parameter int RR_BITS       = RR_BITS_DEF,
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  localparam int CNT_W  = $clog2(MAX_INTERVALS + 1),
  localparam int RSUM_W = RR_BITS + CNT_W,
  localparam int SQ_W   = 2 * RR_BITS + CNT_W
) (
  input  logic               clk,
  input  logic               rst,
  input  win_ctrl_t          ctrl,
  input  logic [RR_BITS-1:0] rr,
  input  logic [THR_W-1:0]   threshold,
  output win_stat_t          stat,
  output logic [CNT_W-1:0]   kept_total,
  output logic [CNT_W-1:0]   pair_total,
  output logic [RSUM_W-1:0]  kept_rr_sum,
  output logic [SQ_W-1:0]    squared_diff_sum
);

  localparam int PROD_W = THR_W + RR_BITS;

  localparam logic [2:0] W_IDLE   = 3'd0;
  localparam logic [2:0] W_RIGHT  = 3'd1;
  localparam logic [2:0] W_LEFT   = 3'd2;
  localparam logic [2:0] W_RETIRE = 3'd3;
  localparam logic [2:0] W_END    = 3'd4;

  logic [2:0]         state;
  logic [RR_BITS-1:0] rr_cur;
  logic [RR_BITS-1:0] rr_one_back;
  logic [RR_BITS-1:0] rr_two_back;
  logic               last_cur;
  logic               left_match_one_back;
  logic               keep_two_back;
  logic               keep_sel;
  logic               left_new;
  logic               final_retire;
  logic               invalid_seen;
  logic [CNT_W-1:0]   item_count;

  logic [THR_W-1:0]   mul_a;
  logic [RR_BITS-1:0] mul_b;
  logic [PROD_W-1:0]  product;
  logic [RR_BITS-1:0] diff_cur;
  logic [RR_BITS-1:0] diff_old;
  logic [PROD_W-1:0]  diff_cur_sh;
  logic               close;

  always_comb begin
    diff_cur = (rr_one_back > rr_cur) ? rr_one_back - rr_cur : rr_cur - rr_one_back;
    diff_old = (rr_one_back > rr_two_back) ? rr_one_back - rr_two_back
                                           : rr_two_back - rr_one_back;
    mul_a = threshold;
    mul_b = rr_cur;
    case (state)
      W_LEFT:   mul_b = rr_one_back;
      W_RETIRE: begin
        mul_a = THR_W'(diff_old);
        mul_b = diff_old;
      end
      default: ;
    endcase
    product     = PROD_W'(mul_a) * PROD_W'(mul_b);
    diff_cur_sh = {diff_cur, {THR_W{1'b0}}};
    close       = diff_cur_sh <= product;
  end

  assign stat.done    = (state == W_END && !(last_cur && !invalid_seen)) ||
                        (state == W_RETIRE && final_retire);
  assign stat.invalid = invalid_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= W_IDLE;
      final_retire        <= 1'b0;
      rr_one_back         <= '0;
      rr_two_back         <= '0;
      left_match_one_back <= 1'b0;
      keep_two_back       <= 1'b0;
      item_count          <= '0;
      kept_total          <= '0;
      pair_total          <= '0;
      kept_rr_sum         <= '0;
      squared_diff_sum    <= '0;
      invalid_seen        <= 1'b0;
    end else begin
      case (state)
        W_IDLE: begin
          if (ctrl.clear) begin
            rr_one_back         <= '0;
            rr_two_back         <= '0;
            left_match_one_back <= 1'b0;
            keep_two_back       <= 1'b0;
            item_count          <= '0;
            kept_total          <= '0;
            pair_total          <= '0;
            kept_rr_sum         <= '0;
            squared_diff_sum    <= '0;
            invalid_seen        <= 1'b0;
          end else if (ctrl.start) begin
            rr_cur   <= rr;
            last_cur <= ctrl.last;
            state    <= W_END;
            if (item_count >= CNT_W'(MAX_INTERVALS)) begin
              invalid_seen <= 1'b1;
            end else begin
              item_count <= item_count + 1'b1;
              if (rr == '0 || invalid_seen) begin
                invalid_seen <= 1'b1;
              end else if (item_count == '0) begin
                rr_one_back         <= rr;
                left_match_one_back <= 1'b0;
              end else begin
                state <= W_RIGHT;
              end
            end
          end
        end
        W_RIGHT: begin
          keep_sel <= left_match_one_back | close;
          state    <= W_LEFT;
        end
        W_LEFT: begin
          left_new <= close;
          state    <= W_RETIRE;
        end
        W_RETIRE: begin
          if (keep_sel) begin
            kept_total  <= kept_total + 1'b1;
            kept_rr_sum <= kept_rr_sum + RSUM_W'(rr_one_back);
            if (keep_two_back) begin
              squared_diff_sum <= squared_diff_sum + SQ_W'(product);
              pair_total       <= pair_total + 1'b1;
            end
          end
          keep_two_back <= keep_sel;
          rr_two_back   <= rr_one_back;
          if (final_retire) begin
            final_retire <= 1'b0;
            state        <= W_IDLE;
          end else begin
            rr_one_back         <= rr_cur;
            left_match_one_back <= left_new;
            state               <= W_END;
          end
        end
        W_END: begin
          // last interval is decided on its left neighbour only
          if (last_cur && !invalid_seen) begin
            keep_sel     <= (item_count == CNT_W'(1)) | left_match_one_back;
            final_retire <= 1'b1;
            state        <= W_RETIRE;
          end else begin
            state <= W_IDLE;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/rr_artifact_filter_rmssd_chk.sv
`timescale 1ns / 1ps
// Checker for rr_artifact_filter_rmssd: watches the config port and both request
// streams, predicts each window summary and compares it field by field.
// Depends on rrafr_pkg and the rrafr_in_if / rrafr_out_if interfaces.
module rr_artifact_filter_rmssd_chk import rrafr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rrafr_in_if                  beat,
  rrafr_out_if                 summary,
  output int                   errors,
  output int                   pending
);

  localparam int WIN_MAX = MAX_INTERVALS_DEF;
  localparam int RW      = RR_BITS_DEF;

  typedef struct {
    logic [RMSSD_W-1:0]      rmssd_q4;
    logic                    rmssd_valid;
    logic [HR_W-1:0]         mean_hr_q8;
    logic                    mean_hr_valid;
    logic [KEPT_COUNT_W-1:0] kept_count;
    logic [DIFF_COUNT_W-1:0] diff_count;
    logic                    usable;
    logic                    window_invalid;
  } win_summary_t;

  win_summary_t expected_summaries[$];

  logic [THR_W-1:0]  thr_q  = THR_RESET;
  logic [MINK_W-1:0] mink_q = MINK_RESET;

  // window state
  logic [RW-1:0]     rr_settled, rr_held;
  bit                held_left_ok, settled_kept;
  int unsigned       n_items, n_kept, n_pairs;
  longint unsigned   kept_sum, sq_sum;
  bit                window_bad;

  task automatic clear_window();
    rr_settled   = '0;
    rr_held      = '0;
    held_left_ok = 0;
    settled_kept = 0;
    n_items      = 0;
    n_kept       = 0;
    n_pairs      = 0;
    kept_sum     = 0;
    sq_sum       = 0;
    window_bad   = 0;
  endtask

  function automatic longint unsigned abs_diff(input logic [RW-1:0] a, input logic [RW-1:0] b);
    return (a > b) ? 64'(a - b) : 64'(b - a);
  endfunction

  // a is within the threshold relative to neighbor b
  function automatic bit near(input logic [RW-1:0] a, input logic [RW-1:0] b);
    return (abs_diff(a, b) << 16) <= 64'(thr_q) * 64'(b);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, t;
    int i;
    r = 0;
    for (i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // decide the held interval and move it to the settled slot
  task automatic settle(input bit keep);
    longint unsigned step;
    if (keep) begin
      n_kept++;
      kept_sum += 64'(rr_held);
      if (settled_kept) begin
        step = abs_diff(rr_held, rr_settled);
        sq_sum += step * step;
        n_pairs++;
      end
    end
    settled_kept = keep;
    rr_settled   = rr_held;
  endtask

  task automatic absorb_interval(input logic [RW-1:0] rr, input logic last);
    win_summary_t    exp;
    longint unsigned rms, hr;
    bit              left_ok;
    if (n_items >= WIN_MAX) begin
      window_bad = 1;
    end else begin
      n_items++;
      if (rr == '0) window_bad = 1;
      if (!window_bad) begin
        left_ok = 0;
        if (n_items > 1) begin
          settle(held_left_ok || near(rr_held, rr));
          left_ok = near(rr, rr_held);
        end
        rr_held      = rr;
        held_left_ok = left_ok;
      end
    end
    if (!last) return;

    exp = '{default: '0};
    rms = 0;
    hr  = 0;
    if (!window_bad) begin
      settle((n_items == 1) ? 1'b1 : held_left_ok);
      if (n_pairs >= 1) begin
        rms = root_floor((sq_sum << RMS_FRAC_BITS) / 64'(n_pairs));
        if (rms > 64'(RMSSD_MAX)) rms = 64'(RMSSD_MAX);
        exp.rmssd_valid = 1;
        exp.rmssd_q4    = rms[RMSSD_W-1:0];
      end
      if (n_kept >= 1 && kept_sum != 0) begin
        hr = (64'(HR_SCALE) * 64'(n_kept)) / kept_sum;
        if (hr > 64'(HR_MAX)) hr = 64'(HR_MAX);
        exp.mean_hr_valid = 1;
        exp.mean_hr_q8    = hr[HR_W-1:0];
      end
      exp.kept_count = n_kept[KEPT_COUNT_W-1:0];
      exp.diff_count = n_pairs[DIFF_COUNT_W-1:0];
      exp.usable     = (n_kept >= mink_q) && (n_pairs >= MIN_DIFFS) && rms > 0 && hr > 0;
    end
    exp.window_invalid = window_bad;
    expected_summaries.push_back(exp);
    clear_window();
  endtask

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    if (got != want) begin
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
      errors++;
    end
  endtask

  task automatic compare_summary();
    win_summary_t exp;
    if (expected_summaries.size() == 0) begin
      report("summary request with no window pending", 1, 0);
      return;
    end
    exp = expected_summaries.pop_front();
    report("rmssd_q4",       summary.rmssd_q4,       exp.rmssd_q4);
    report("rmssd_valid",    summary.rmssd_valid,    exp.rmssd_valid);
    report("mean_hr_q8",     summary.mean_hr_q8,     exp.mean_hr_q8);
    report("mean_hr_valid",  summary.mean_hr_valid,  exp.mean_hr_valid);
    report("kept_count",     summary.kept_count,     exp.kept_count);
    report("diff_count",     summary.diff_count,     exp.diff_count);
    report("usable",         summary.usable,         exp.usable);
    report("window_invalid", summary.window_invalid, exp.window_invalid);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr_q  = THR_RESET;
      mink_q = MINK_RESET;
      clear_window();
      expected_summaries.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ARTIFACT_THRESHOLD: thr_q  = cfg_data[THR_W-1:0];
          REG_MIN_KEPT:           mink_q = cfg_data[MINK_W-1:0];
          default: ;
        endcase
      end
      if (beat.valid && beat.ready) absorb_interval(beat.rr_ms, beat.last_interval);
      if (summary.valid && summary.ready) compare_summary();
    end
    pending = expected_summaries.size();
  end

endmodule

// File: tb/sv/rr_artifact_filter_rmssd_tb.sv
`timescale 1ns / 1ps
// Top of the rr_artifact_filter_rmssd testbench: clock, reset, config writes and
// interval windows with random gaps; verdict from the checker. Depends on
// rrafr_pkg, the rrafr interfaces, the block and rr_artifact_filter_rmssd_chk.
module rr_artifact_filter_rmssd_tb;
  import rrafr_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASE_ITEMS  = 170;

  typedef enum {SHAPE_CLEAN, SHAPE_PHYSIO, SHAPE_WILD} shape_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;
  int                   idle_cycles = 0;
  int                   random_sent = 0;
  bit                   no_gaps = 0;

  rrafr_in_if  beat();
  rrafr_out_if summary();

  always #2 clk = ~clk;

  rr_artifact_filter_rmssd i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .summary   (summary)
  );

  rr_artifact_filter_rmssd_chk i_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .summary   (summary),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (rst || (beat.valid && beat.ready) || (summary.valid && summary.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rr_artifact_filter_rmssd verification failed");
      $finish;
    end
  end

  // summary sink with random stalls
  initial begin
    int stall;
    summary.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        @(negedge clk);
        summary.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      summary.ready <= 1'b1;
      do @(posedge clk); while (!(summary.valid && summary.ready));
    end
  end

  task automatic send_interval(input logic [RR_BITS_DEF-1:0] rr, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      beat.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    beat.valid         <= 1'b1;
    beat.rr_ms         <= rr;
    beat.last_interval <= last;
    do @(posedge clk); while (!beat.ready);
  endtask

  // drop valid, let every summary come back and the block go quiet
  task automatic hold_off();
    @(negedge clk);
    beat.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [THR_W-1:0] thr, input logic [MINK_W-1:0] mink);
    hold_off();
    write_reg(REG_ARTIFACT_THRESHOLD, thr);
    write_reg(REG_MIN_KEPT, CFG_W'(mink));
  endtask

  function automatic logic [RR_BITS_DEF-1:0] draw_rr(input shape_t shape, input int base);
    int r, v;
    r = $urandom_range(0, 99);
    case (shape)
      SHAPE_WILD:  v = (r < 4) ? 0 : int'($urandom_range(1, 4095));
      SHAPE_CLEAN: v = base + int'($urandom_range(0, base * 6 / 100)) - base * 3 / 100;
      default: begin
        if (r < 1)       v = 0;
        else if (r < 6)  v = int'($urandom_range(1, 4095));
        else if (r < 14) v = r[0] ? base * 3 / 2 : base / 2;
        else             v = base + int'($urandom_range(0, base / 5)) - base / 10;
      end
    endcase
    if (v > 4095) v = 4095;
    return v[RR_BITS_DEF-1:0];
  endfunction

  task automatic send_window(input shape_t shape, input int len);
    int base;
    int i;
    base = (shape == SHAPE_CLEAN) ? $urandom_range(600, 1200) : $urandom_range(300, 2000);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) send_interval(draw_rr(shape, base), i == len - 1);
  endtask

  initial begin
    int thr, mink, len, sel, phase_end;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    beat.valid         = 1'b0;
    beat.rr_ms         = '0;
    beat.last_interval = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-interval windows, zero intervals, an artifact, a pair
    send_interval(12'd4095, 1'b1);
    send_interval(12'd1, 1'b1);
    send_interval(12'd0, 1'b1);
    send_interval(12'd800, 1'b0);
    send_interval(12'd0, 1'b0);
    send_interval(12'd820, 1'b1);
    send_interval(12'd1000, 1'b0);
    send_interval(12'd1300, 1'b0);
    send_interval(12'd1000, 1'b0);
    send_interval(12'd1010, 1'b1);
    send_interval(12'd1000, 1'b0);
    send_interval(12'd1050, 1'b1);

    // zero threshold: only equal neighbors match
    set_config(16'd0, 11'd0);
    send_interval(12'd700, 1'b0);
    send_interval(12'd700, 1'b0);
    send_interval(12'd701, 1'b0);
    send_interval(12'd700, 1'b1);

    // full threshold, huge swings
    set_config(16'hFFFF, 11'd1);
    send_interval(12'd1, 1'b0);
    send_interval(12'd4095, 1'b0);
    send_interval(12'd1, 1'b0);
    send_interval(12'd4095, 1'b0);
    send_interval(12'd2048, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       thr = $urandom_range(0, 65535);
        1:       thr = 0;
        2:       thr = 65535;
        default: thr = $urandom_range(3000, 20000);
      endcase
      mink = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 40);
      set_config(thr[THR_W-1:0], mink[MINK_W-1:0]);
      phase_end = random_sent + PHASE_ITEMS;
      while (random_sent < phase_end) begin
        sel = $urandom_range(0, 9);
        if (sel < 7)      len = $urandom_range(1, 40);
        else if (sel < 9) len = $urandom_range(41, 160);
        else              len = $urandom_range(1, 3);
        send_window(($urandom_range(0, 4) == 0) ? SHAPE_WILD : SHAPE_PHYSIO, len);
        random_sent += len;
      end
    end

    @(negedge clk);
    beat.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("rr_artifact_filter_rmssd verification clean");
    end else begin
      $display("rr_artifact_filter_rmssd verification failed");
    end
    $finish;
  end

endmodule
